/* rtl/core/umcd_pkg.sv */
// ----------------------------------------------------------------------------
// umcd_pkg
// Shared types and constants of the motor command line decoder.
// ----------------------------------------------------------------------------
package umcd_pkg;

	localparam int unsigned LINE_CNT_W = 5;
	localparam logic [LINE_CNT_W-1:0] MAX_LINE = 5'd20;

	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_T     = 8'h54;
	localparam logic [7:0] CHR_P     = 8'h50;
	localparam logic [7:0] CHR_C     = 8'h43;
	localparam logic [7:0] CHR_G     = 8'h47;
	localparam logic [7:0] CHR_STAR  = 8'h2A;
	localparam logic [7:0] CHR_QUEST = 8'h3F;
	localparam logic [7:0] CHR_I     = 8'h49;
	localparam logic [7:0] CHR_D     = 8'h44;
	localparam logic [7:0] CHR_N     = 8'h4E;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_UNDER = 8'h5F;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_VT_CR = 8'h0D;

	typedef enum logic [2:0] {
		ACT_TORQUE   = 3'd0,
		ACT_POSITION = 3'd1,
		ACT_COLOR    = 3'd2,
		ACT_STATUS   = 3'd3,
		ACT_IDENTITY = 3'd4
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [7:0]         direction;
		logic [7:0]         power;
		logic signed [31:0] target;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} cmd_t;

endpackage

/* rtl/core/umcd_if.sv */
// ----------------------------------------------------------------------------
// umcd_rx_if / umcd_cmd_if
// Valid/ready channels for received bytes and for decoded commands.
// ----------------------------------------------------------------------------
interface umcd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface umcd_cmd_if;
	logic                valid;
	logic                ready;
	umcd_pkg::action_t   action;
	logic [7:0]          direction;
	logic [7:0]          power;
	logic signed [31:0]  target;
	logic [7:0]          red;
	logic [7:0]          green;
	logic [7:0]          blue;

	modport source (output valid, output action, output direction, output power,
		output target, output red, output green, output blue, input ready);
	modport sink (input valid, input action, input direction, input power,
		input target, input red, input green, input blue, output ready);
endinterface

/* rtl/core/uart_motor_command_decoder.sv */
// ----------------------------------------------------------------------------
// uart_motor_command_decoder
// Decodes ASCII motor command lines one received byte per transfer.
// A command result is registered into an output entry with the transfer of its CR or LF.
// Throughput: one byte per cycle while the input is not stalled; the parser updates once per accepted byte.
// Input stalls only while both output entries hold results that wait.
// Reset clears the line counter, the parser and both output entries.
// ----------------------------------------------------------------------------
module uart_motor_command_decoder (
	input  logic         clk,
	input  logic         arst_n,
	umcd_rx_if.sink      rx,
	umcd_cmd_if.source   cmd
);

	typedef enum logic [2:0] {
		PH_START, PH_SPACE, PH_NUMBER, PH_QUERY, PH_DONE, PH_DEAD
	} phase_t;

	logic [umcd_pkg::LINE_CNT_W-1:0] lc_q, lc_n;
	logic [7:0]  letter_q, letter_n;
	phase_t      ph_q, ph_n;
	logic [31:0] v1_q, v2_q, v3_q, v1_n, v2_n, v3_n;
	logic        neg_q, neg_n, seen_q, seen_n, qm_q, qm_n;
	logic [1:0]  mf_q, mf_n;

	logic [7:0]  c;
	logic        accept, push, pop, eol, is_digit, is_space, wr_en, idn_ok;
	logic [31:0] cur_v, digit, mul10, wr_val;
	logic [1:0]  needed;
	umcd_pkg::cmd_t res, main_q, skid_q;
	logic        main_v_q, skid_v_q;

	assign c      = rx.rx_byte;
	assign accept = rx.valid && rx.ready;
	assign pop    = main_v_q && cmd.ready;
	assign rx.ready = !skid_v_q;

	assign is_digit = c inside {[umcd_pkg::CHR_ZERO:umcd_pkg::CHR_NINE]};
	assign is_space = c inside {umcd_pkg::CHR_SPACE, [umcd_pkg::CHR_TAB:umcd_pkg::CHR_VT_CR]};
	assign eol      = c inside {umcd_pkg::CHR_CR, umcd_pkg::CHR_LF};
	assign digit    = {28'd0, c[3:0]};
	assign cur_v    = (mf_q == 2'd0) ? v1_q : ((mf_q == 2'd1) ? v2_q : v3_q);
	assign mul10    = (cur_v << 3) + (cur_v << 1) + digit;
	assign needed   = (letter_q == umcd_pkg::CHR_C) ? 2'd3 : 2'd2;

	always_comb begin
		case (lc_q)
			5'd1:    idn_ok = (c == umcd_pkg::CHR_I);
			5'd2:    idn_ok = (c == umcd_pkg::CHR_D);
			5'd3:    idn_ok = (c == umcd_pkg::CHR_N);
			5'd4:    idn_ok = (c == umcd_pkg::CHR_QUEST);
			default: idn_ok = 1'b0;
		endcase
	end

	always_comb begin
		lc_n = lc_q;
		letter_n = letter_q;
		ph_n = ph_q;
		v1_n = v1_q;
		v2_n = v2_q;
		v3_n = v3_q;
		neg_n = neg_q;
		seen_n = seen_q;
		mf_n = mf_q;
		qm_n = qm_q;
		wr_en = 1'b0;
		wr_val = mul10;
		res = '0;
		push = 1'b0;

		if (lc_q < umcd_pkg::MAX_LINE) begin
			lc_n = lc_q + 5'd1;
			case (ph_q)
				PH_START: begin
					letter_n = c;
					if (c inside {umcd_pkg::CHR_T, umcd_pkg::CHR_P, umcd_pkg::CHR_C}) begin
						ph_n = PH_SPACE;
					end else if (c inside {umcd_pkg::CHR_G, umcd_pkg::CHR_STAR}) begin
						ph_n = PH_QUERY;
					end else begin
						ph_n = PH_DEAD;
					end
				end
				PH_SPACE: begin
					if (is_space) begin
						ph_n = PH_SPACE;
					end else if (c inside {umcd_pkg::CHR_PLUS, umcd_pkg::CHR_MINUS}) begin
						neg_n = (c == umcd_pkg::CHR_MINUS);
						seen_n = 1'b0;
						ph_n = PH_NUMBER;
					end else if (is_digit) begin
						wr_en = 1'b1;
						wr_val = digit;
						seen_n = 1'b1;
						ph_n = PH_NUMBER;
					end else begin
						ph_n = PH_DEAD;
					end
				end
				PH_NUMBER: begin
					if (is_digit) begin
						wr_en = 1'b1;
						wr_val = mul10;
						seen_n = 1'b1;
					end else if (!seen_q) begin
						ph_n = PH_DEAD;
					end else begin
						wr_en = neg_q;
						wr_val = 32'd0 - cur_v;
						mf_n = mf_q + 2'd1;
						neg_n = 1'b0;
						seen_n = 1'b0;
						if (mf_n >= needed) begin
							ph_n = PH_DONE;
						end else if (c == umcd_pkg::CHR_UNDER) begin
							ph_n = PH_SPACE;
						end else begin
							ph_n = PH_DEAD;
						end
					end
				end
				PH_QUERY: begin
					if (letter_q == umcd_pkg::CHR_G) begin
						if (lc_q == 5'd1 && c == umcd_pkg::CHR_QUEST) begin
							qm_n = 1'b1;
							ph_n = PH_DONE;
						end else begin
							ph_n = PH_DEAD;
						end
					end else if (idn_ok) begin
						if (lc_q == 5'd4) begin
							qm_n = 1'b1;
							ph_n = PH_DONE;
						end
					end else begin
						ph_n = PH_DEAD;
					end
				end
				default: begin
					ph_n = ph_q;
				end
			endcase
			if (wr_en) begin
				case (mf_q)
					2'd0:    v1_n = wr_val;
					2'd1:    v2_n = wr_val;
					default: v3_n = wr_val;
				endcase
			end
		end else begin
			lc_n = '0;
			letter_n = '0;
			ph_n = PH_START;
			v1_n = '0;
			v2_n = '0;
			v3_n = '0;
			neg_n = 1'b0;
			seen_n = 1'b0;
			mf_n = '0;
			qm_n = 1'b0;
		end

		if (eol && lc_n > 5'd1 && ph_n == PH_DONE) begin
			if (letter_n == umcd_pkg::CHR_T) begin
				push = 1'b1;
				res.action = umcd_pkg::ACT_TORQUE;
				res.direction = v1_n[7:0];
				res.power = v2_n[7:0];
			end else if (letter_n == umcd_pkg::CHR_P) begin
				push = 1'b1;
				res.action = umcd_pkg::ACT_POSITION;
				res.power = v2_n[7:0];
				res.target = v1_n;
			end else if (letter_n == umcd_pkg::CHR_C) begin
				push = 1'b1;
				res.action = umcd_pkg::ACT_COLOR;
				res.red = v1_n[7:0];
				res.green = v2_n[7:0];
				res.blue = v3_n[7:0];
			end else if (letter_n == umcd_pkg::CHR_G && qm_n) begin
				push = 1'b1;
				res.action = umcd_pkg::ACT_STATUS;
			end else if (letter_n == umcd_pkg::CHR_STAR && qm_n) begin
				push = 1'b1;
				res.action = umcd_pkg::ACT_IDENTITY;
			end
		end

		if (eol) begin
			lc_n = '0;
			letter_n = '0;
			ph_n = PH_START;
			v1_n = '0;
			v2_n = '0;
			v3_n = '0;
			neg_n = 1'b0;
			seen_n = 1'b0;
			mf_n = '0;
			qm_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= '0;
			letter_q <= '0;
			ph_q <= PH_START;
			v1_q <= '0;
			v2_q <= '0;
			v3_q <= '0;
			neg_q <= 1'b0;
			seen_q <= 1'b0;
			mf_q <= '0;
			qm_q <= 1'b0;
		end else if (accept) begin
			lc_q <= lc_n;
			letter_q <= letter_n;
			ph_q <= ph_n;
			v1_q <= v1_n;
			v2_q <= v2_n;
			v3_q <= v3_n;
			neg_q <= neg_n;
			seen_q <= seen_n;
			mf_q <= mf_n;
			qm_q <= qm_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !main_v_q) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= accept && push;
			end else begin
				main_v_q <= accept && push;
			end
		end else if (accept && push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_v_q) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				if (accept && push) begin
					skid_q <= res;
				end
			end else if (accept && push) begin
				main_q <= res;
			end
		end else if (accept && push) begin
			skid_q <= res;
		end
	end

	assign cmd.valid     = main_v_q;
	assign cmd.action    = main_q.action;
	assign cmd.direction = main_q.direction;
	assign cmd.power     = main_q.power;
	assign cmd.target    = main_q.target;
	assign cmd.red       = main_q.red;
	assign cmd.green     = main_q.green;
	assign cmd.blue      = main_q.blue;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the motor command line decoder. A scoreboard
// class decodes every accepted byte on its own and keeps the commands that
// the decoder must produce; each command transfer is compared with the
// oldest of them. Directed lines come first, then random command lines,
// noise and overflow lines, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
	import umcd_pkg::*;

	localparam int  BYTES_TARGET = 1700;
	localparam logic [7:0] CHR_NUL = 8'h00;
	localparam logic [7:0] CHR_VT  = 8'h0B;
	localparam logic [7:0] CHR_FF  = 8'h0C;
	localparam logic [7:0] CHR_TOP = 8'hFF;

	typedef enum logic [2:0] {
		PH_START,
		PH_SPACE,
		PH_NUMBER,
		PH_QUERY,
		PH_DONE,
		PH_DEAD
	} scan_phase_t;

	class cmd_scoreboard;
		cmd_t        expected_q[$];
		int          mismatches;
		int          checked;
		int          per_action[5];
		logic [4:0]  line_len;
		logic [7:0]  letter;
		scan_phase_t phase;
		logic [31:0] values[3];
		logic        negative;
		logic        digit_seen;
		logic [1:0]  fields_done;
		logic        query_hit;

		function new();
			mismatches = 0;
			checked = 0;
			foreach (per_action[i]) per_action[i] = 0;
			clear_line();
		endfunction

		function void clear_line();
			line_len = '0;
			letter = '0;
			phase = PH_START;
			foreach (values[i]) values[i] = '0;
			negative = 1'b0;
			digit_seen = 1'b0;
			fields_done = '0;
			query_hit = 1'b0;
		endfunction

		function void parse_char(logic [7:0] c, logic [4:0] pos);
			int          idx;
			logic [31:0] digit;
			logic [1:0]  needed;
			logic [7:0]  want;
			idx = (fields_done == 2'd0) ? 0 : (fields_done == 2'd1) ? 1 : 2;
			digit = {24'h0, c} - {24'h0, CHR_ZERO};
			needed = (letter == CHR_C) ? 2'd3 : 2'd2;
			case (pos)
				5'd1: want = CHR_I;
				5'd2: want = CHR_D;
				5'd3: want = CHR_N;
				default: want = CHR_QUEST;
			endcase
			case (phase)
				PH_START: begin
					letter = c;
					if (c == CHR_T || c == CHR_P || c == CHR_C) begin
						phase = PH_SPACE;
					end else if (c == CHR_G || c == CHR_STAR) begin
						phase = PH_QUERY;
					end else begin
						phase = PH_DEAD;
					end
				end
				PH_SPACE: begin
					if (c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR)) begin
						phase = PH_SPACE;
					end else if (c == CHR_PLUS || c == CHR_MINUS) begin
						negative = (c == CHR_MINUS);
						digit_seen = 1'b0;
						phase = PH_NUMBER;
					end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
						values[idx] = digit;
						digit_seen = 1'b1;
						phase = PH_NUMBER;
					end else begin
						phase = PH_DEAD;
					end
				end
				PH_NUMBER: begin
					if (c >= CHR_ZERO && c <= CHR_NINE) begin
						values[idx] = values[idx] * 32'd10 + digit;
						digit_seen = 1'b1;
					end else if (!digit_seen) begin
						phase = PH_DEAD;
					end else begin
						if (negative) values[idx] = 32'd0 - values[idx];
						fields_done = fields_done + 2'd1;
						negative = 1'b0;
						digit_seen = 1'b0;
						if (fields_done >= needed) begin
							phase = PH_DONE;
						end else if (c == CHR_UNDER) begin
							phase = PH_SPACE;
						end else begin
							phase = PH_DEAD;
						end
					end
				end
				PH_QUERY: begin
					if (letter == CHR_G) begin
						if (pos == 5'd1 && c == CHR_QUEST) begin
							query_hit = 1'b1;
							phase = PH_DONE;
						end else begin
							phase = PH_DEAD;
						end
					end else if (pos >= 5'd1 && pos <= 5'd4 && c == want) begin
						if (pos == 5'd4) begin
							query_hit = 1'b1;
							phase = PH_DONE;
						end
					end else begin
						phase = PH_DEAD;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void note_byte(logic [7:0] c);
			cmd_t res;
			bit   found;
			if (line_len < MAX_LINE) begin
				parse_char(c, line_len);
				line_len = line_len + 5'd1;
			end else begin
				clear_line();
			end
			if (c == CHR_CR || c == CHR_LF) begin
				if (line_len > 5'd1 && phase == PH_DONE) begin
					res = '0;
					found = 1'b1;
					if (letter == CHR_T) begin
						res.action = ACT_TORQUE;
						res.direction = values[0][7:0];
						res.power = values[1][7:0];
					end else if (letter == CHR_P) begin
						res.action = ACT_POSITION;
						res.power = values[1][7:0];
						res.target = values[0];
					end else if (letter == CHR_C) begin
						res.action = ACT_COLOR;
						res.red = values[0][7:0];
						res.green = values[1][7:0];
						res.blue = values[2][7:0];
					end else if (letter == CHR_G && query_hit) begin
						res.action = ACT_STATUS;
					end else if (letter == CHR_STAR && query_hit) begin
						res.action = ACT_IDENTITY;
					end else begin
						found = 1'b0;
					end
					if (found) expected_q.push_back(res);
				end
				clear_line();
			end
		endfunction

		function void log_fault(string what, cmd_t want, cmd_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s", $time, what);
				$display("  expected act=%0d dir=%0d pow=%0d tgt=%0d rgb=%0d/%0d/%0d",
					want.action, want.direction, want.power, want.target,
					want.red, want.green, want.blue);
				$display("  actual   act=%0d dir=%0d pow=%0d tgt=%0d rgb=%0d/%0d/%0d",
					got.action, got.direction, got.power, got.target,
					got.red, got.green, got.blue);
			end
		endfunction

		function void check_cmd(cmd_t got);
			cmd_t want;
			if (expected_q.size() == 0) begin
				log_fault("command transfer with nothing expected", '0, got);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.action <= ACT_IDENTITY) per_action[want.action]++;
			if (got.action !== want.action || got.direction !== want.direction ||
				got.power !== want.power || got.target !== want.target ||
				got.red !== want.red || got.green !== want.green ||
				got.blue !== want.blue) begin
				log_fault("command field mismatch", want, got);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   bytes_sent;
	int   lines_sent;
	cmd_t seen_cmd;
	cmd_scoreboard sb;

	umcd_rx_if  rx_if();
	umcd_cmd_if cmd_if();

	uart_motor_command_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.cmd    (cmd_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	initial begin
		int burst;
		int gap;
		cmd_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			cmd_if.ready <= 1'b1;
			burst = $urandom_range(1, 12);
			repeat (burst) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				cmd_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready) begin
				seen_cmd.action = cmd_if.action;
				seen_cmd.direction = cmd_if.direction;
				seen_cmd.power = cmd_if.power;
				seen_cmd.target = cmd_if.target;
				seen_cmd.red = cmd_if.red;
				seen_cmd.green = cmd_if.green;
				seen_cmd.blue = cmd_if.blue;
				sb.check_cmd(seen_cmd);
			end
			if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		bytes_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		foreach (s[i]) send_byte(s[i]);
	endtask

	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic void put_number(ref logic [7:0] q[$]);
		int         r;
		int         n_digits;
		logic [7:0] blanks[4];
		blanks = '{CHR_SPACE, CHR_TAB, CHR_VT, CHR_FF};
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) q.push_back(blanks[$urandom_range(0, 3)]);
		end
		r = $urandom_range(0, 9);
		if (r == 0) q.push_back(CHR_PLUS);
		else if (r < 3) q.push_back(CHR_MINUS);
		r = $urandom_range(0, 99);
		n_digits = (r < 60) ? $urandom_range(1, 3) :
			(r < 90) ? $urandom_range(4, 6) : $urandom_range(7, 11);
		repeat (n_digits) q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void build_command(ref logic [7:0] q[$]);
		case ($urandom_range(0, 4))
			0: begin
				q.push_back(CHR_T);
				put_number(q);
				q.push_back(CHR_UNDER);
				put_number(q);
			end
			1: begin
				q.push_back(CHR_P);
				put_number(q);
				q.push_back(CHR_UNDER);
				put_number(q);
			end
			2: begin
				q.push_back(CHR_C);
				put_number(q);
				q.push_back(CHR_UNDER);
				put_number(q);
				q.push_back(CHR_UNDER);
				put_number(q);
			end
			3: begin
				q.push_back(CHR_G);
				q.push_back(CHR_QUEST);
			end
			default: begin
				q.push_back(CHR_STAR);
				q.push_back(CHR_I);
				q.push_back(CHR_D);
				q.push_back(CHR_N);
				q.push_back(CHR_QUEST);
			end
		endcase
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(33, 126)));
		end
	endfunction

	function automatic void end_line(ref logic [7:0] q[$]);
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) q.push_back(CHR_CR);
		else if (r < 9) q.push_back(CHR_LF);
		else begin
			q.push_back(CHR_CR);
			q.push_back(CHR_LF);
		end
	endfunction

	task automatic run_directed();
		send_text("T0_0\r");
		send_text("T255_255\n");
		send_text("T \t256_ -1\r");
		send_text("P-2147483648_7\r");
		send_text("P+2147483647_255\n");
		send_text("P4294967297_1\r");
		send_text("C1_2_3\r");
		send_text("C255_0_128\n");
		send_text("G?\r");
		send_text("*IDN?\n");
		send_text("\r");
		send_text("G\r");
		send_text("G?junk\r\n");
		send_text("T1_2");
		repeat (15) send_byte(CHR_SPACE);
		send_byte(CHR_CR);
		send_text("T3_4");
		repeat (16) send_byte(CHR_SPACE);
		send_byte(CHR_CR);
		send_text("G?\r");
		send_text("T_5\rT5-6\rT-_1\rC1_2\rP1 2\r");
		send_text("X1_2\r*IDX?\rG!\r");
		send_text("T1_2");
		send_byte(CHR_NUL);
		send_byte(CHR_CR);
		send_text("T1");
		send_byte(CHR_NUL);
		send_text("_2\r*ID");
		send_byte(CHR_NUL);
		send_text("?\r");
		send_byte(CHR_TOP);
		send_text("1_2\r");
		lines_sent += 30;
	endtask

	task automatic run_random();
		logic [7:0] line_q[$];
		int         r;
		int         pad_to;
		while (bytes_sent < BYTES_TARGET) begin
			line_q = {};
			if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
			if ($urandom_range(0, 59) == 0) wait_drained();
			r = $urandom_range(0, 99);
			if (r < 70) begin
				build_command(line_q);
				end_line(line_q);
			end else if (r < 82) begin
				build_command(line_q);
				line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
				end_line(line_q);
			end else if (r < 92) begin
				repeat ($urandom_range(1, 24)) line_q.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 0) end_line(line_q);
			end else begin
				build_command(line_q);
				pad_to = $urandom_range(18, 23);
				while (line_q.size() < pad_to) begin
					line_q.push_back(($urandom_range(0, 1) == 0) ? CHR_SPACE :
						8'($urandom_range(33, 126)));
				end
				end_line(line_q);
			end
			foreach (line_q[i]) send_byte(line_q[i]);
			lines_sent++;
		end
	endtask

	initial begin
		sb = new();
		no_idle = 1'b0;
		bytes_sent = 0;
		lines_sent = 0;
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		run_random();
		rx_if.valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes in about %0d lines; %0d commands compared.",
			bytes_sent, lines_sent, sb.checked);
		$display("Torque %0d, position %0d, color %0d, status %0d, identity %0d; %0d faults.",
			sb.per_action[ACT_TORQUE], sb.per_action[ACT_POSITION],
			sb.per_action[ACT_COLOR], sb.per_action[ACT_STATUS],
			sb.per_action[ACT_IDENTITY], sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
